// ===== rtl/irpwd_pkg.sv =====
// ----------------------------------------------------------------------------
// irpwd_pkg
// Shared types, constants and window helper for the IR pulse width decoder.
// ----------------------------------------------------------------------------
package irpwd_pkg;

    localparam int TIME_BITS = 16;
    localparam int CODE_BITS = 25;
    localparam int CNT_BITS  = $clog2(CODE_BITS + 1);
    localparam int DUR_BITS  = TIME_BITS + 1;
    localparam int ADDR_BITS = 5;
    localparam int DATA_BITS = 32;
    localparam int IDX_BITS  = 3;

    // register index within the configuration map
    typedef enum logic [IDX_BITS-1:0] {
        REG_RELOAD    = 3'd0,
        REG_START     = 3'd1,
        REG_HIGH_ZERO = 3'd2,
        REG_HIGH_ONE  = 3'd3,
        REG_LOW_ZERO  = 3'd4,
        REG_LOW_ONE   = 3'd5,
        REG_TOLERANCE = 3'd6
    } reg_idx_t;

    localparam logic [TIME_BITS-1:0] RELOAD_RST    = TIME_BITS'(3000);
    localparam logic [TIME_BITS-1:0] START_RST     = TIME_BITS'(300);
    localparam logic [TIME_BITS-1:0] HIGH_ZERO_RST = TIME_BITS'(50);
    localparam logic [TIME_BITS-1:0] HIGH_ONE_RST  = TIME_BITS'(150);
    localparam logic [TIME_BITS-1:0] LOW_ZERO_RST  = TIME_BITS'(150);
    localparam logic [TIME_BITS-1:0] LOW_ONE_RST   = TIME_BITS'(50);
    localparam logic [TIME_BITS-1:0] TOLERANCE_RST = TIME_BITS'(20);

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] reload;
        logic [TIME_BITS-1:0] start;
        logic [TIME_BITS-1:0] high_zero;
        logic [TIME_BITS-1:0] high_one;
        logic [TIME_BITS-1:0] low_zero;
        logic [TIME_BITS-1:0] low_one;
        logic [TIME_BITS-1:0] tolerance;
    } cfg_t;

    typedef struct packed {
        logic                 hit;
        logic [CODE_BITS-1:0] code;
    } dec_out_t;

    // duration within centre +/- tol; a negative (wrapped) duration is huge
    function automatic logic in_window(input logic                 d_neg,
                                       input logic [DUR_BITS-1:0]  d_val,
                                       input logic [TIME_BITS-1:0] centre,
                                       input logic [TIME_BITS-1:0] tol);
        logic [DUR_BITS-1:0] lo;
        logic [DUR_BITS-1:0] hi;
        lo = (centre > tol) ? {1'b0, centre - tol} : '0;
        hi = {1'b0, centre} + {1'b0, tol};
        return !d_neg && (d_val >= lo) && (d_val <= hi);
    endfunction

endpackage

// ===== rtl/irpwd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// irpwd_cfg_regs
// APB register file holding the timing thresholds of the decoder.
// ----------------------------------------------------------------------------
module irpwd_cfg_regs
    import irpwd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready,
    output cfg_t                 cfg
);

    cfg_t                 cfg_reg;
    logic                 wr_en;
    reg_idx_t             idx;
    logic [TIME_BITS-1:0] wval;
    logic [TIME_BITS-1:0] rval;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[ADDR_BITS-1:2]);
    assign wval   = pwdata[TIME_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reload    <= RELOAD_RST;
            cfg_reg.start     <= START_RST;
            cfg_reg.high_zero <= HIGH_ZERO_RST;
            cfg_reg.high_one  <= HIGH_ONE_RST;
            cfg_reg.low_zero  <= LOW_ZERO_RST;
            cfg_reg.low_one   <= LOW_ONE_RST;
            cfg_reg.tolerance <= TOLERANCE_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_RELOAD:    cfg_reg.reload    <= wval;
                REG_START:     cfg_reg.start     <= wval;
                REG_HIGH_ZERO: cfg_reg.high_zero <= wval;
                REG_HIGH_ONE:  cfg_reg.high_one  <= wval;
                REG_LOW_ZERO:  cfg_reg.low_zero  <= wval;
                REG_LOW_ONE:   cfg_reg.low_one   <= wval;
                REG_TOLERANCE: cfg_reg.tolerance <= wval;
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_RELOAD:    rval = cfg_reg.reload;
            REG_START:     rval = cfg_reg.start;
            REG_HIGH_ZERO: rval = cfg_reg.high_zero;
            REG_HIGH_ONE:  rval = cfg_reg.high_one;
            REG_LOW_ZERO:  rval = cfg_reg.low_zero;
            REG_LOW_ONE:   rval = cfg_reg.low_one;
            REG_TOLERANCE: rval = cfg_reg.tolerance;
            default:       rval = '0;
        endcase
    end

    assign prdata = {{(DATA_BITS - TIME_BITS){1'b0}}, rval};
    assign cfg    = cfg_reg;

endmodule

// ===== rtl/irpwd_decode.sv =====
// ----------------------------------------------------------------------------
// irpwd_decode
// Duration measurement, window checks and frame state for one edge per cycle while step is high.
// ----------------------------------------------------------------------------
module irpwd_decode
    import irpwd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 step,
    input  logic [TIME_BITS-1:0] edge_time,
    output dec_out_t             dec
);

    phase_t               phase_reg, phase_next;
    logic [TIME_BITS-1:0] prev_reg, prev_next;
    logic                 have_reg, have_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic [CODE_BITS-1:0] shift_reg, shift_next;
    logic                 last_reg, last_next;

    logic [DUR_BITS:0]    wrap_sum;
    logic                 d_neg;
    logic [DUR_BITS-1:0]  d_val;
    logic                 is_start;
    logic                 hz_ok, ho_ok, lz_ok, lo_ok;
    logic [CODE_BITS-1:0] bit_sel;
    logic [CODE_BITS-1:0] shift_or;
    logic                 bit_val;

    // wrapped duration can go negative for stamps beyond the reload value
    assign wrap_sum = {2'b00, cfg.reload} + {2'b00, edge_time} - {2'b00, prev_reg};

    always_comb
    begin
        if (prev_reg > edge_time)
        begin
            d_neg = wrap_sum[DUR_BITS];
            d_val = wrap_sum[DUR_BITS-1:0];
        end
        else
        begin
            d_neg = 1'b0;
            d_val = {1'b0, edge_time - prev_reg};
        end
    end

    assign is_start = d_neg || (d_val > {1'b0, cfg.start});
    assign hz_ok    = in_window(d_neg, d_val, cfg.high_zero, cfg.tolerance);
    assign ho_ok    = in_window(d_neg, d_val, cfg.high_one, cfg.tolerance);
    assign lz_ok    = in_window(d_neg, d_val, cfg.low_zero, cfg.tolerance);
    assign lo_ok    = in_window(d_neg, d_val, cfg.low_one, cfg.tolerance);
    assign bit_val  = !hz_ok;

    always_comb
    begin
        for (int i = 0; i < CODE_BITS; i++)
        begin
            bit_sel[i] = (count_reg == CNT_BITS'(i));
        end
    end

    assign shift_or = bit_val ? (shift_reg | bit_sel) : shift_reg;

    always_comb
    begin
        phase_next = phase_reg;
        prev_next  = prev_reg;
        have_next  = have_reg;
        count_next = count_reg;
        shift_next = shift_reg;
        last_next  = last_reg;
        dec.hit    = 1'b0;
        dec.code   = shift_or;
        if (step)
        begin
            prev_next = edge_time;
            have_next = 1'b1;
            if (have_reg)
            begin
                case (phase_reg)
                    PH_HIGH:
                    begin
                        if (hz_ok || ho_ok)
                        begin
                            last_next = bit_val;
                            if (count_reg == CNT_BITS'(CODE_BITS - 1))
                            begin
                                dec.hit    = 1'b1;
                                count_next = '0;
                                shift_next = '0;
                                phase_next = PH_HUNT;
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                                shift_next = shift_or;
                                phase_next = PH_LOW;
                            end
                        end
                        else
                        begin
                            count_next = '0;
                            shift_next = '0;
                            phase_next = is_start ? PH_HIGH : PH_HUNT;
                        end
                    end
                    PH_LOW:
                    begin
                        if (last_reg ? lo_ok : lz_ok)
                        begin
                            phase_next = PH_HIGH;
                        end
                        else
                        begin
                            count_next = '0;
                            shift_next = '0;
                            phase_next = is_start ? PH_HIGH : PH_HUNT;
                        end
                    end
                    default:
                    begin
                        count_next = '0;
                        shift_next = '0;
                        phase_next = is_start ? PH_HIGH : PH_HUNT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            prev_reg  <= '0;
            have_reg  <= 1'b0;
            count_reg <= '0;
            shift_reg <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            prev_reg  <= prev_next;
            have_reg  <= have_next;
            count_reg <= count_next;
            shift_reg <= shift_next;
            last_reg  <= last_next;
        end
    end

endmodule

// ===== rtl/ir_pulse_width_decoder.sv =====
// ----------------------------------------------------------------------------
// ir_pulse_width_decoder
// Online decoder for pulse-width coded IR remote frames from edge timestamps.
// ----------------------------------------------------------------------------
// Each input beat carries one capture counter timestamp of a signal edge. The
// block takes a beat in every cycle unless the output stalls: a timestamp is
// held in an input register and decoded against the thresholds, and a
// finished code lands in an output register. Input stalls only while the
// output register holds a code that the sink has not taken. The first edge
// after reset only sets the time base. The user must write thresholds over
// the APB port while no edge is in flight; the block does not enforce it.
module ir_pulse_width_decoder
    import irpwd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // [15:0] edge_time
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // [24:0] code_word, [31:25] zero
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready
);

    cfg_t                 cfg;
    dec_out_t             dec;
    logic                 in_valid_reg;
    logic [TIME_BITS-1:0] in_time_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [CODE_BITS-1:0] out_code_reg;
    logic                 advance;

    irpwd_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    irpwd_decode u_dec (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .step      (advance),
        .edge_time (in_time_reg),
        .dec       (dec)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_time_reg <= s_tdata[TIME_BITS-1:0];
        end
    end

    always_comb
    begin
        if (advance && dec.hit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && dec.hit)
        begin
            out_code_reg <= dec.code;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(32 - CODE_BITS){1'b0}}, out_code_reg};

endmodule

// ===== rtl/irpwd_checker.sv =====
// ----------------------------------------------------------------------------
// irpwd_checker
// Port-level checks for the IR pulse width decoder, bound to the top level.
// ----------------------------------------------------------------------------
module irpwd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // a stalled code beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("code beat changed while stalled");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[31:25] == 7'd0)
        else $error("code padding bits not zero");

    // a new code beat comes from a taken edge beat
    a_code_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("code beat without a matching edge beat");

    // input backs up only behind a held code beat
    a_back_press: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output back pressure");

endmodule

bind ir_pulse_width_decoder irpwd_checker u_irpwd_checker (.*);
